// File: sv/pcac_pkg.sv
// Package for the pileup column allele caller: widths, allele and register codes,
// and the structs passed between the lanes, the ranking logic and the output stage.
// No dependencies.
`default_nettype none

package pcac_pkg;

   localparam int COUNT_W     = 16;
   localparam int CODE_W      = 3;
   localparam int THR_W       = 16;
   localparam int NUM_ALLELES = 5;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // thr (16 bits) times count plus reference count (17 bits)
   localparam int PROD_W = THR_W + COUNT_W + 1;
   // reference count plus up to five allele counts
   localparam int SUM_W  = COUNT_W + 3;

   localparam int MAX_READS = 65535;
   localparam int DEPTH_CAP = (MAX_READS > 65535) ? 65535 : MAX_READS;

   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [CODE_W-1:0]      code_type;
   typedef logic [THR_W-1:0]       thr_type;
   typedef logic [NUM_ALLELES-1:0] mask_type;

   // allele codes
   localparam code_type CODE_A    = 3'd0;
   localparam code_type CODE_C    = 3'd1;
   localparam code_type CODE_G    = 3'd2;
   localparam code_type CODE_T    = 3'd3;
   localparam code_type CODE_DEL  = 3'd4;
   localparam code_type CODE_N    = 3'd5;
   localparam code_type CODE_NONE = 3'd7;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SNP_MIN    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEL_MIN    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INS_MIN    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REPORT_ALL = 8'd3;

   // what one lane finds for its allele
   typedef struct packed {
      logic pass;     // fraction above its threshold
      logic reach;    // count at least the reference count
      logic nonzero;
   } lane_type;

   // top-three ranking after the deletion runner-up rule
   typedef struct packed {
      code_type maj;
      code_type mnr;
      logic     mnr_ok;
   } rank_type;

   // one column handed to the output stage
   typedef struct packed {
      mask_type                        keep;
      count_type [NUM_ALLELES-1:0]     cnt;
      count_type                       refc;
      count_type                       nrd;
   } column_type;

endpackage

`default_nettype wire

// File: sv/pileup_column_allele_caller_unit.sv
// Pileup column allele caller, top level: input stage, five allele lanes, merge
// stage and output stage. Depends on pcac_pkg, pcac_lane, pcac_rank, pcac_emit.
//
// Takes one pileup column per clock unless the output stalls, and returns its
// alternate alleles as words on the rsp channel, lowest code first, last_allele set
// on the final one; a column with nothing to report gives no word at all. The first
// word of a column goes through stage P, stage K and the output register. A column
// giving k words holds the single output register until its last word is taken, so
// the rate is one column per cycle only while columns give at most one word; the
// pipeline stalls behind the output register. Thresholds and the report-all
// bit are written through the csr channel (always ready, unknown indexes ignored)
// and reset to zero; write them only while no column is in flight.
`default_nettype none

module pileup_column_allele_caller_unit (
   input  logic                                clock,
   input  logic                                reset,
   // column input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pcac_pkg::count_type                 req_count_a,
   input  pcac_pkg::count_type                 req_count_c,
   input  pcac_pkg::count_type                 req_count_g,
   input  pcac_pkg::count_type                 req_count_t,
   input  pcac_pkg::count_type                 req_count_gap,
   input  pcac_pkg::count_type                 req_count_n,
   input  pcac_pkg::count_type                 req_row_count,
   input  pcac_pkg::code_type                  req_ref_code,
   // allele output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pcac_pkg::code_type                  rsp_alt_code,
   output pcac_pkg::count_type                 rsp_alt_count,
   output pcac_pkg::count_type                 rsp_ref_count,
   output pcac_pkg::count_type                 rsp_allele_depth,
   output pcac_pkg::count_type                 rsp_row_depth,
   output logic                                rsp_last_allele,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcac_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcac_pkg::*;

   // configuration registers
   thr_type snp_ff, del_ff, ins_ff;
   logic    report_all_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         snp_ff        <= '0;
         del_ff        <= '0;
         ins_ff        <= '0;
         report_all_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SNP_MIN:    snp_ff        <= csr_wdata[THR_W-1:0];
            REG_DEL_MIN:    del_ff        <= csr_wdata[THR_W-1:0];
            REG_INS_MIN:    ins_ff        <= csr_wdata[THR_W-1:0];
            REG_REPORT_ALL: report_all_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // flow control: each stage moves when the one after it has room
   // ---------------------------------------------------------------------------
   logic p_v_ff, p_v_in, p_ready;
   logic k_v_ff, k_v_in, k_ready;
   logic s_ready;

   assign k_ready   = !k_v_ff || s_ready;
   assign p_ready   = !p_v_ff || k_ready;
   assign req_ready = p_ready;
   assign p_v_in    = p_ready ? req_valid : p_v_ff;
   assign k_v_in    = k_ready ? p_v_ff : k_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         k_v_ff <= 1'b0;
      end else begin
         p_v_ff <= p_v_in;
         k_v_ff <= k_v_in;
      end
   end

   // ---------------------------------------------------------------------------
   // input decode, straight from the ports
   // ---------------------------------------------------------------------------
   count_type [NUM_ALLELES-1:0] req_cnt;
   code_type                    rc_in;
   count_type                   refc_in, nrd_in;
   logic                        ref_gap_in, empty_in;
   rank_type                    rank_in;

   assign req_cnt = {req_count_gap, req_count_t, req_count_g, req_count_c, req_count_a};

   // codes six and seven read as an N reference
   assign rc_in      = (req_ref_code > CODE_N) ? CODE_N : req_ref_code;
   assign ref_gap_in = rc_in >= CODE_DEL;
   assign empty_in   = req_cnt == '0;
   assign nrd_in     = (req_row_count > req_count_n) ? (req_row_count - req_count_n) : '0;

   // an N reference has no count of its own
   always_comb begin
      case (rc_in)
         CODE_A:   refc_in = req_count_a;
         CODE_C:   refc_in = req_count_c;
         CODE_G:   refc_in = req_count_g;
         CODE_T:   refc_in = req_count_t;
         CODE_DEL: refc_in = req_count_gap;
         default:  refc_in = '0;
      endcase
   end

   pcac_rank u_rank (
      .cnt  (req_cnt),
      .rc   (rc_in),
      .rank (rank_in)
   );

   // stage P: ranking, reference info; lanes hold counts and products
   code_type  rc_ff;
   count_type refc_ff, nrd_ff;
   logic      empty_ff;
   rank_type  rank_ff;

   always_ff @(posedge clock) begin
      if (p_ready) begin
         rc_ff    <= rc_in;
         refc_ff  <= refc_in;
         nrd_ff   <= nrd_in;
         empty_ff <= empty_in;
         rank_ff  <= rank_in;
      end
   end

   // ---------------------------------------------------------------------------
   // allele lanes. The denominator is count plus reference count in both modes:
   // the default mode only tests the runner-up when the reference is the top
   // count. Deletion uses its own threshold; bases use the insertion threshold at
   // a gap or N reference, the substitution threshold otherwise.
   // ---------------------------------------------------------------------------
   lane_type  lane_res [NUM_ALLELES];
   count_type lane_cnt [NUM_ALLELES];

   for (genvar g = 0; g < NUM_ALLELES; g++) begin : g_lane
      thr_type thr;

      if (g == int'(CODE_DEL)) begin : g_del
         assign thr = del_ff;
      end else begin : g_base
         assign thr = ref_gap_in ? ins_ff : snp_ff;
      end

      pcac_lane u_lane (
         .clock     (clock),
         .load      (p_ready),
         .count_in  (req_cnt[g]),
         .refc_in   (refc_in),
         .thr_in    (thr),
         .refc_held (refc_ff),
         .count     (lane_cnt[g]),
         .result    (lane_res[g])
      );
   end

   // ---------------------------------------------------------------------------
   // merge: pick the kept alleles from lane findings and ranking
   // ---------------------------------------------------------------------------
   logic       all_mode;
   mask_type   rep_vec, dflt_vec;
   column_type k_col_in, k_col_ff;

   always_comb begin
      // report-all falls back to the default mode at a gap or N reference
      all_mode = report_all_ff && (rc_ff < CODE_DEL);
      for (int i = 0; i < NUM_ALLELES; i++) begin
         rep_vec[i] = (rc_ff != code_type'(i)) && lane_res[i].nonzero &&
                      (lane_res[i].reach || lane_res[i].pass);
         if (rank_ff.maj != rc_ff) begin
            dflt_vec[i] = rank_ff.maj == code_type'(i);
         end else begin
            dflt_vec[i] = rank_ff.mnr_ok && (rank_ff.mnr == code_type'(i)) &&
                          lane_res[i].pass;
         end
         k_col_in.cnt[i] = lane_cnt[i];
      end
      if (empty_ff) begin
         k_col_in.keep = '0;
      end else if (all_mode) begin
         k_col_in.keep = rep_vec;
      end else begin
         k_col_in.keep = dflt_vec;
      end
      k_col_in.refc = refc_ff;
      k_col_in.nrd  = nrd_ff;
   end

   // stage K
   always_ff @(posedge clock) begin
      if (k_ready) begin
         k_col_ff <= k_col_in;
      end
   end

   // ---------------------------------------------------------------------------
   // output register and word sequencing
   // ---------------------------------------------------------------------------
   pcac_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .col_valid        (k_v_ff),
      .col              (k_col_ff),
      .col_ready        (s_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alt_code     (rsp_alt_code),
      .rsp_alt_count    (rsp_alt_count),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_allele_depth (rsp_allele_depth),
      .rsp_row_depth    (rsp_row_depth),
      .rsp_last_allele  (rsp_last_allele)
   );

endmodule

`default_nettype wire

// File: sv/pcac_lane.sv
// One allele lane: registers its count and the threshold cross-product, then
// compares. Depends on pcac_pkg.
`default_nettype none

module pcac_lane (
   input  logic                clock,
   input  logic                load,
   input  pcac_pkg::count_type count_in,
   input  pcac_pkg::count_type refc_in,
   input  pcac_pkg::thr_type   thr_in,
   input  pcac_pkg::count_type refc_held,
   output pcac_pkg::count_type count,
   output pcac_pkg::lane_type  result
);
   import pcac_pkg::*;

   logic [COUNT_W:0]  den;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   count_type         count_ff;

   assign den     = {1'b0, count_in} + {1'b0, refc_in};
   assign prod_in = {{(PROD_W-THR_W){1'b0}}, thr_in} * {{(PROD_W-COUNT_W-1){1'b0}}, den};

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
         prod_ff  <= prod_in;
      end
   end

   // count * 2^16 > thr * (count + ref)
   assign result.pass    = {1'b0, count_ff, {THR_W{1'b0}}} > prod_ff;
   assign result.reach   = count_ff >= refc_held;
   assign result.nonzero = count_ff != '0;
   assign count          = count_ff;

endmodule

`default_nettype wire

// File: sv/pcac_rank.sv
// Top-three ranking of the five allele counts, strict compares in code order,
// with the deletion runner-up rule. Combinational. Depends on pcac_pkg.
`default_nettype none

module pcac_rank (
   input  pcac_pkg::count_type [pcac_pkg::NUM_ALLELES-1:0] cnt,
   input  pcac_pkg::code_type                               rc,
   output pcac_pkg::rank_type                               rank
);
   import pcac_pkg::*;

   code_type  maj, mnr, mnr2;
   count_type majc, mnrc, mnr2c;
   logic      swap;

   always_comb begin
      maj   = CODE_NONE;
      mnr   = CODE_NONE;
      mnr2  = CODE_NONE;
      majc  = '0;
      mnrc  = '0;
      mnr2c = '0;
      for (int i = 0; i < NUM_ALLELES; i++) begin
         if (cnt[i] > majc) begin
            mnr2  = mnr;
            mnr2c = mnrc;
            mnr   = maj;
            mnrc  = majc;
            maj   = code_type'(i);
            majc  = cnt[i];
         end else if (cnt[i] > mnrc) begin
            mnr2  = mnr;
            mnr2c = mnrc;
            mnr   = code_type'(i);
            mnrc  = cnt[i];
         end else if (cnt[i] > mnr2c) begin
            mnr2  = code_type'(i);
            mnr2c = cnt[i];
         end
      end
      // deletion runner-up yields to a third allele above half its count
      swap = (maj == rc) && (mnr == CODE_DEL) && (rc != CODE_DEL) &&
             ({mnr2c, 1'b0} > {1'b0, mnrc});
      rank.maj    = maj;
      rank.mnr    = swap ? mnr2 : mnr;
      rank.mnr_ok = swap ? (mnr2c != '0) : (mnrc != '0);
   end

endmodule

`default_nettype wire

// File: sv/pcac_emit.sv
// Output stage: holds one column and sends its kept alleles one word at a time,
// lowest code first. Depends on pcac_pkg.
`default_nettype none

module pcac_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   col_valid,
   input  pcac_pkg::column_type   col,
   output logic                   col_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pcac_pkg::code_type     rsp_alt_code,
   output pcac_pkg::count_type    rsp_alt_count,
   output pcac_pkg::count_type    rsp_ref_count,
   output pcac_pkg::count_type    rsp_allele_depth,
   output pcac_pkg::count_type    rsp_row_depth,
   output logic                   rsp_last_allele
);
   import pcac_pkg::*;

   mask_type                    mask_ff, mask_in, low;
   count_type [NUM_ALLELES-1:0] cnt_ff;
   count_type                   refc_ff, depth_ff, nrd_ff, depth_in, cur_count;
   code_type                    cur_code;
   logic [SUM_W-1:0]            sum;
   logic                        take, last, load;

   // saturating allele depth of the incoming column
   always_comb begin
      sum = SUM_W'(col.refc);
      for (int i = 0; i < NUM_ALLELES; i++) begin
         if (col.keep[i]) begin
            sum = sum + SUM_W'(col.cnt[i]);
         end
      end
      depth_in = (sum > SUM_W'(DEPTH_CAP)) ? COUNT_W'(DEPTH_CAP) : sum[COUNT_W-1:0];
   end

   // lowest pending allele
   always_comb begin
      cur_code  = CODE_A;
      cur_count = '0;
      for (int i = NUM_ALLELES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_code  = code_type'(i);
            cur_count = cnt_ff[i];
         end
      end
   end

   assign low       = mask_ff & (~mask_ff + mask_type'(1));
   assign last      = (mask_ff & ~low) == '0;
   assign rsp_valid = mask_ff != '0;
   assign take      = rsp_valid && rsp_ready;
   assign col_ready = !rsp_valid || (take && last);
   assign load      = col_valid && col_ready;

   always_comb begin
      if (load) begin
         mask_in = col.keep;
      end else if (take) begin
         mask_in = mask_ff & ~low;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff   <= col.cnt;
         refc_ff  <= col.refc;
         nrd_ff   <= col.nrd;
         depth_ff <= depth_in;
      end
   end

   assign rsp_alt_code     = cur_code;
   assign rsp_alt_count    = cur_count;
   assign rsp_ref_count    = refc_ff;
   assign rsp_allele_depth = depth_ff;
   assign rsp_row_depth    = nrd_ff;
   assign rsp_last_allele  = last;

endmodule

`default_nettype wire

// File: sv/pcac_checker.sv
// Port-level checks for the pileup column allele caller, bound to the top level.
// Depends on pcac_pkg and pileup_column_allele_caller_unit.
`default_nettype none

module pcac_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pcac_pkg::code_type  rsp_alt_code,
   input pcac_pkg::count_type rsp_alt_count,
   input pcac_pkg::count_type rsp_ref_count,
   input pcac_pkg::count_type rsp_allele_depth,
   input pcac_pkg::count_type rsp_row_depth,
   input logic                rsp_last_allele
);
   import pcac_pkg::*;

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alt_code) &&
      $stable(rsp_alt_count) && $stable(rsp_last_allele))
      else $error("stalled rsp word changed");

   // the rest of a column follows at once, in rising code order
   a_ascend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_allele |=>
      rsp_valid && (rsp_alt_code > $past(rsp_alt_code)))
      else $error("column words not back to back in ascending code");

   // column-wide fields agree across the words of one column
   a_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_allele |=>
      $stable(rsp_ref_count) && $stable(rsp_allele_depth) && $stable(rsp_row_depth))
      else $error("column fields differ within one column");

   // nothing comes out straight after reset
   a_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind pileup_column_allele_caller_unit pcac_checker u_pcac_checker (.*);

`default_nettype wire

// File: tb/sv/tb_pileup_column_allele_caller_unit.sv
// Self-checking bench for the pileup column allele caller: directed and random columns
// checked word by word against an in-bench allele predictor.
// Depends on pcac_pkg and pileup_column_allele_caller_unit.
`timescale 1ns / 1ps

module tb_pileup_column_allele_caller_unit;
   import pcac_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;
   localparam int SEGMENTS     = 6;
   localparam int SEGMENT_COLS = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 8'hA5;
   // reference codes beyond N, read by the block as an N reference
   localparam code_type CODE_SPARE_LO = 3'd6;
   localparam code_type CODE_SPARE_HI = 3'd7;

   typedef longint unsigned wide_type;

   // one pileup column as the bench holds it; drain makes the driver wait for
   // every outstanding word before presenting this column
   typedef struct {
      count_type cnt [NUM_ALLELES];
      count_type n_reads;
      count_type rows;
      code_type  ref_sym;
      bit        drain;
   } column_word_type;

   // one allele word as the block should show it
   typedef struct {
      code_type  alt_code;
      count_type alt_count;
      count_type ref_reads;
      count_type allele_depth;
      count_type row_depth;
      logic      last_allele;
   } allele_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   count_type              req_count_a = '0;
   count_type              req_count_c = '0;
   count_type              req_count_g = '0;
   count_type              req_count_t = '0;
   count_type              req_count_gap = '0;
   count_type              req_count_n = '0;
   count_type              req_row_count = '0;
   code_type               req_ref_code = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   code_type               rsp_alt_code;
   count_type              rsp_alt_count;
   count_type              rsp_ref_count;
   count_type              rsp_allele_depth;
   count_type              rsp_row_depth;
   logic                   rsp_last_allele;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow copy of the block's registers, updated on each csr handshake
   thr_type snp_thr    = '0;
   thr_type del_thr    = '0;
   thr_type ins_thr    = '0;
   bit      report_all = 1'b0;

   column_word_type columns_pending[$];
   allele_word_type alleles_due[$];
   column_word_type col_on_bus;
   allele_word_type due_word;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures      = 0;
   int cycles        = 0;
   int columns_taken = 0;
   int alleles_seen  = 0;
   int multi_columns = 0;

   pileup_column_allele_caller_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_count_a      (req_count_a),
      .req_count_c      (req_count_c),
      .req_count_g      (req_count_g),
      .req_count_t      (req_count_t),
      .req_count_gap    (req_count_gap),
      .req_count_n      (req_count_n),
      .req_row_count    (req_row_count),
      .req_ref_code     (req_ref_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alt_code     (rsp_alt_code),
      .rsp_alt_count    (rsp_alt_count),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_allele_depth (rsp_allele_depth),
      .rsp_row_depth    (rsp_row_depth),
      .rsp_last_allele  (rsp_last_allele),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Allele predictor
   // ------------------------------------------------------------------

   // exact fraction test: num / den > thr / 2^16, by cross-multiplying
   function automatic bit above_fraction(wide_type num, wide_type den, thr_type thr);
      return (num << 16) > (wide_type'(thr) * den);
   endfunction

   // works out the words a column should give and queues them in code order
   function automatic void call_alleles(column_word_type col);
      wide_type        cnt [NUM_ALLELES];
      bit              keep [NUM_ALLELES];
      wide_type        total, refc, nrd, depth, majc, mnrc, mnr2c, den;
      int              rc, maj, mnr, mnr2, last, found;
      bit              ref_gap, pass;
      allele_word_type w;
      total = 0;
      for (int i = 0; i < NUM_ALLELES; i++) begin
         cnt[i]  = wide_type'(col.cnt[i]);
         keep[i] = 1'b0;
         total  += cnt[i];
      end
      rc = int'(col.ref_sym);
      // codes six and seven behave as an N reference
      if (rc > CODE_N) rc = CODE_N;
      ref_gap = rc >= CODE_DEL;
      // an N reference has no reads of its own
      refc = (rc < CODE_N) ? cnt[rc] : 0;
      nrd  = (col.rows > col.n_reads) ? wide_type'(col.rows - col.n_reads) : 0;
      if (total == 0) return;

      if (report_all && !ref_gap) begin
         for (int i = 0; i < NUM_ALLELES; i++) begin
            if (i == rc || cnt[i] == 0) continue;
            if (i == CODE_DEL) pass = above_fraction(cnt[i], cnt[i] + refc, del_thr);
            else pass = above_fraction(cnt[i], cnt[i] + refc, snp_thr);
            if (cnt[i] >= refc || pass) keep[i] = 1'b1;
         end
      end else begin
         // top three, strict compares, so ties go to the lower code
         maj = -1; mnr = -1; mnr2 = -1;
         majc = 0; mnrc = 0; mnr2c = 0;
         for (int i = 0; i < NUM_ALLELES; i++) begin
            if (cnt[i] > majc) begin
               mnr2 = mnr; mnr2c = mnrc;
               mnr  = maj; mnrc  = majc;
               maj  = i;   majc  = cnt[i];
            end else if (cnt[i] > mnrc) begin
               mnr2 = mnr; mnr2c = mnrc;
               mnr  = i;   mnrc  = cnt[i];
            end else if (cnt[i] > mnr2c) begin
               mnr2 = i;   mnr2c = cnt[i];
            end
         end
         // deletion runner-up gives way to a third allele above half its count
         if (mnr != -1 && maj != -1 && mnr2 != -1 && rc == maj && mnr == CODE_DEL &&
             rc != CODE_DEL && 2 * mnr2c > mnrc) begin
            mnr  = mnr2;
            mnrc = mnr2c;
         end
         if (maj != rc) begin
            if (maj >= 0 && majc > 0) keep[maj] = 1'b1;
         end else if (mnr >= 0 && mnr != rc && mnrc > 0) begin
            den  = majc + mnrc;
            pass = (mnr == CODE_DEL && above_fraction(mnrc, den, del_thr)) ||
                   (mnr != CODE_DEL && !ref_gap && above_fraction(mnrc, den, snp_thr)) ||
                   (ref_gap && above_fraction(mnrc, den, ins_thr));
            if (pass) keep[mnr] = 1'b1;
         end
      end

      depth = refc;
      last  = -1;
      found = 0;
      for (int i = 0; i < NUM_ALLELES; i++) begin
         if (keep[i]) begin
            depth += cnt[i];
            last   = i;
            found++;
         end
      end
      if (last < 0) return;
      if (depth > DEPTH_CAP) depth = wide_type'(DEPTH_CAP);
      if (found > 1) multi_columns++;

      for (int i = 0; i < NUM_ALLELES; i++) begin
         if (!keep[i]) continue;
         w.alt_code     = code_type'(i);
         w.alt_count    = count_type'(cnt[i]);
         w.ref_reads    = count_type'(refc);
         w.allele_depth = count_type'(depth);
         w.row_depth    = count_type'(nrd);
         w.last_allele  = (i == last);
         alleles_due    = {alleles_due, w};
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic void enqueue_column(column_word_type col);
      columns_pending = {columns_pending, col};
   endfunction

   function automatic column_word_type column_of(int a, int c, int g, int t, int gap,
                                                 int n, int rows, code_type rcode);
      column_word_type col;
      col.cnt[CODE_A]   = count_type'(a);
      col.cnt[CODE_C]   = count_type'(c);
      col.cnt[CODE_G]   = count_type'(g);
      col.cnt[CODE_T]   = count_type'(t);
      col.cnt[CODE_DEL] = count_type'(gap);
      col.n_reads       = count_type'(n);
      col.rows          = count_type'(rows);
      col.ref_sym       = rcode;
      col.drain         = 1'b0;
      return col;
   endfunction

   // depth scale: mostly shallow columns, some deep, a few at full range
   function automatic int pick_scale();
      int r;
      r = $urandom_range(99);
      return (r < 60) ? 20 : (r < 90) ? 2000 : 65535;
   endfunction

   function automatic column_word_type random_column();
      column_word_type col;
      int kind, top, refb, third, slot, sum;
      kind        = $urandom_range(99);
      col.drain   = 1'b0;
      col.n_reads = count_type'($urandom_range(15));
      col.ref_sym = code_type'($urandom_range(3));
      for (int i = 0; i < NUM_ALLELES; i++) col.cnt[i] = '0;

      if (kind < 15) begin
         // raw noise over the whole field range, reference codes six and seven too
         for (int i = 0; i < NUM_ALLELES; i++) col.cnt[i] = count_type'($urandom);
         col.n_reads = count_type'($urandom);
         col.rows    = count_type'($urandom);
         col.ref_sym = code_type'($urandom_range(7));
         return col;
      end

      if (kind < 20) begin
         // empty column, only N reads if any
         col.ref_sym = code_type'($urandom_range(7));
      end else if (kind < 35) begin
         // ties among the counts
         top   = pick_scale();
         third = $urandom_range(top);
         for (int i = 0; i < NUM_ALLELES; i++)
            col.cnt[i] = count_type'($urandom_range(1) ? third : $urandom_range(top));
         col.ref_sym = code_type'($urandom_range(5));
      end else if (kind < 50) begin
         // base reference on top, deletion runner-up, third allele near half of it
         refb              = $urandom_range(3);
         col.ref_sym       = code_type'(refb);
         top               = $urandom_range(40, 2000);
         col.cnt[refb]     = count_type'(top);
         col.cnt[CODE_DEL] = count_type'($urandom_range(8, top - 1));
         third             = col.cnt[CODE_DEL] / 2 + $urandom_range(2);
         if ($urandom_range(3) == 0) third = $urandom_range(col.cnt[CODE_DEL] / 2);
         slot              = (refb + $urandom_range(1, 3)) % 4;
         col.cnt[slot]     = count_type'(third);
         for (int i = 0; i < 4; i++)
            if (i != refb && i != slot) col.cnt[i] = count_type'($urandom_range(third));
      end else begin
         // typical column: strong reference, one candidate, a little noise
         top         = pick_scale();
         refb        = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(4, 5);
         col.ref_sym = code_type'(refb);
         if (refb < NUM_ALLELES) col.cnt[refb] = count_type'($urandom_range(top / 2, top));
         slot          = $urandom_range(4);
         col.cnt[slot] = count_type'(($urandom_range(4) == 0) ? $urandom_range(top)
                                                              : $urandom_range(top / 8));
         slot = $urandom_range(4);
         if (col.cnt[slot] == 0) col.cnt[slot] = count_type'($urandom_range(3));
      end

      sum = int'(col.n_reads);
      for (int i = 0; i < NUM_ALLELES; i++) sum += int'(col.cnt[i]);
      // now and then no more rows than N reads, so row depth floors at zero
      if ($urandom_range(9) == 0) col.rows = count_type'($urandom_range(col.n_reads));
      else col.rows = count_type'((sum + 20 > 65535) ? 65535 : sum + $urandom_range(20));
      return col;
   endfunction

   // ------------------------------------------------------------------
   // Register writes, from the main sequence only while the block is idle
   // ------------------------------------------------------------------

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SNP_MIN:    snp_thr    = data;
         REG_DEL_MIN:    del_thr    = data;
         REG_INS_MIN:    ins_thr    = data;
         REG_REPORT_ALL: report_all = data[0];
         default: ;     // unmapped index, the block ignores it
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(thr_type snp, thr_type del, thr_type ins, bit all_mode);
      write_reg(REG_SNP_MIN, snp);
      write_reg(REG_DEL_MIN, del);
      write_reg(REG_INS_MIN, ins);
      write_reg(REG_REPORT_ALL, {15'd0, all_mode});
   endtask

   // wait until every column is in and every word out, then let columns that give
   // no word leave the pipeline too
   task automatic settle();
      while (columns_pending.size() != 0 || req_valid || alleles_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Column driver: one word in flight on req, held until accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            call_alleles(col_on_bus);
            columns_taken++;
         end
         if (!req_valid || req_ready) begin
            // a draining column waits here until the word queue is empty
            if (columns_pending.size() != 0 &&
                !(columns_pending[0].drain && alleles_due.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               col_on_bus     = columns_pending.pop_front();
               req_valid     <= 1'b1;
               req_count_a   <= col_on_bus.cnt[CODE_A];
               req_count_c   <= col_on_bus.cnt[CODE_C];
               req_count_g   <= col_on_bus.cnt[CODE_G];
               req_count_t   <= col_on_bus.cnt[CODE_T];
               req_count_gap <= col_on_bus.cnt[CODE_DEL];
               req_count_n   <= col_on_bus.n_reads;
               req_row_count <= col_on_bus.rows;
               req_ref_code  <= col_on_bus.ref_sym;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Allele monitor: every accepted word against the oldest one due
   // ------------------------------------------------------------------
   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (alleles_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, got code %0d count %0h",
                        $time, rsp_alt_code, rsp_alt_count);
               failures++;
            end else begin
               due_word = alleles_due.pop_front();
               alleles_seen++;
               check_field("alt code", 16'(due_word.alt_code), 16'(rsp_alt_code));
               check_field("alt count",    due_word.alt_count,    rsp_alt_count);
               check_field("ref count",    due_word.ref_reads,    rsp_ref_count);
               check_field("allele depth", due_word.allele_depth, rsp_allele_depth);
               check_field("row depth",    due_word.row_depth,    rsp_row_depth);
               check_field("last allele", 16'(due_word.last_allele), 16'(rsp_last_allele));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d words still due", $time, alleles_due.size());
         $display("pileup_column_allele_caller_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      column_word_type col;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, default mode: snp 1/16, del 1/4, ins 1/8
      send_idle_pct = 38;
      recv_idle_pct = 71;
      set_thresholds(16'h1000, 16'h4000, 16'h2000, 1'b0);
      write_reg(REG_UNMAPPED, 16'hFFFF);     // must not disturb any register

      enqueue_column(column_of(0, 0, 0, 0, 0, 0, 0, CODE_A));      // empty
      enqueue_column(column_of(0, 0, 0, 0, 0, 9, 3, CODE_C));      // N reads only
      enqueue_column(column_of(65535, 65535, 65535, 65535, 65535,
                               65535, 65535, CODE_A));              // all at max
      enqueue_column(column_of(15, 1, 0, 0, 0, 0, 16, CODE_A));    // snp on the edge
      enqueue_column(column_of(14, 1, 0, 0, 0, 0, 15, CODE_A));    // just above it
      enqueue_column(column_of(60, 61, 0, 0, 0, 2, 130, CODE_A));  // alt on top
      enqueue_column(column_of(0, 0, 0, 65535, 0, 0, 65535, CODE_C));
      enqueue_column(column_of(100, 0, 21, 0, 40, 0, 161, CODE_A)); // third takes over
      enqueue_column(column_of(100, 0, 20, 0, 40, 0, 160, CODE_A)); // deletion stays
      enqueue_column(column_of(30, 0, 0, 0, 10, 0, 40, CODE_A));   // del on the edge
      enqueue_column(column_of(10, 0, 0, 0, 70, 0, 80, CODE_DEL)); // ins on the edge
      enqueue_column(column_of(10, 0, 0, 0, 60, 0, 70, CODE_DEL)); // ins above
      enqueue_column(column_of(5, 0, 0, 0, 20, 1, 26, CODE_N));    // N reference
      enqueue_column(column_of(5, 0, 0, 0, 20, 1, 26, CODE_SPARE_LO));
      enqueue_column(column_of(30, 3, 0, 0, 0, 0, 33, CODE_SPARE_HI));
      enqueue_column(column_of(0, 200, 0, 0, 0, 500, 100, CODE_A)); // row depth floors
      enqueue_column(column_of(5, 0, 50, 5, 0, 0, 60, CODE_G));    // tied minors
      settle();

      // directed, report-all mode
      set_thresholds(16'h1000, 16'h4000, 16'h2000, 1'b1);
      enqueue_column(column_of(10, 10, 1, 0, 3, 0, 24, CODE_A));
      enqueue_column(column_of(65535, 65535, 65535, 65535, 65535,
                               0, 0, CODE_T));                      // depth saturates
      enqueue_column(column_of(65535, 0, 65535, 0, 65535, 7, 65535, CODE_C));
      enqueue_column(column_of(10, 0, 0, 0, 60, 0, 70, CODE_DEL)); // falls back
      enqueue_column(column_of(5, 6, 0, 0, 0, 0, 11, CODE_SPARE_HI));
      enqueue_column(column_of(0, 0, 0, 0, 0, 4, 4, CODE_G));
      enqueue_column(column_of(1000, 1, 0, 0, 0, 0, 1001, CODE_A));
      settle();

      // random segments: extremes of the thresholds first, then random settings and one
      // at one half; idling shifts from receiver-heavy to sender-heavy to none
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 71 : 0;
         recv_idle_pct = (seg < 2) ? 71 : (seg < 4) ? 38 : 0;
         case (seg)
            0:       set_thresholds(16'h0000, 16'h0000, 16'h0000, 1'b0);
            1:       set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
            4:       set_thresholds(16'h8000, 16'h8000, 16'h8000, 1'b0);
            default: set_thresholds(thr_type'($urandom_range(16'h3000)),
                                    thr_type'($urandom_range(16'h8000)),
                                    thr_type'($urandom_range(16'h6000)), seg[0]);
         endcase
         for (int k = 0; k < SEGMENT_COLS; k++) begin
            col = random_column();
            // hold the sender off until every outstanding word is out, now and then
            col.drain = (k == SEGMENT_COLS / 2) || ($urandom_range(49) == 0);
            enqueue_column(col);
         end
         settle();
      end

      $display("Ran %0d columns over %0d threshold settings in both modes;", columns_taken,
               SEGMENTS + 2);
      $display("checked %0d allele words, %0d columns gave more than one.", alleles_seen,
               multi_columns);
      if (failures == 0) begin
         $display("pileup_column_allele_caller_unit regression: pass");
      end else begin
         $display("pileup_column_allele_caller_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/pcac_pkg.sv
sv/pcac_lane.sv
sv/pcac_rank.sv
sv/pcac_emit.sv
sv/pileup_column_allele_caller_unit.sv
sv/pcac_checker.sv
tb/sv/tb_pileup_column_allele_caller_unit.sv
